/* rtl/core/tlc_pkg.sv */
// Tile LRU cache package: shared widths, request codes, FSM states and beat structs.
// No dependencies; compile first.
`default_nettype none

package tlc_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int COORD_BITS_DEF = 20;

  localparam int TILE_W  = 20;  // port width of tile_x / tile_y
  localparam int ZOOM_W  = 5;
  localparam int FRAME_W = 32;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_LOOKUP  = 2'd1,
    REQ_INSTALL = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TILE_W-1:0] tile_x;
    logic [TILE_W-1:0] tile_y;
    logic [ZOOM_W-1:0] tile_zoom;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted;
    logic [TILE_W-1:0]  evicted_x;
    logic [TILE_W-1:0]  evicted_y;
    logic [ZOOM_W-1:0]  evicted_zoom;
    logic [COUNT_W-1:0] valid_count;
  } rsp_t;

  // flags of the search token that walks the cell chain
  typedef struct packed {
    logic found;  // a valid entry matched the key
    logic free;   // an invalid slot was seen
    logic have;   // best-stamp candidate is loaded
  } scan_t;

  // entry write broadcast from the controller
  typedef struct packed {
    logic we;
    logic set_key;
  } upd_t;

endpackage

`default_nettype wire

/* rtl/core/tlc_req_if.sv */
// Request channel interface: valid/ready handshake with a tlc_pkg::req_t payload.
// Depends on tlc_pkg.
`default_nettype none

interface tlc_req_if;
  logic          valid;
  logic          ready;
  tlc_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/tlc_rsp_if.sv */
// Result channel interface: valid/ready handshake with a tlc_pkg::rsp_t payload.
// Depends on tlc_pkg.
`default_nettype none

interface tlc_rsp_if;
  logic          valid;
  logic          ready;
  tlc_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/tlc_cell.sv */
// One cache entry plus one stage of the search token chain.
// Depends on tlc_pkg.
`default_nettype none

module tlc_cell #(
  parameter int ENTRIES    = tlc_pkg::ENTRIES_DEF,
  parameter int COORD_BITS = tlc_pkg::COORD_BITS_DEF,
  parameter int CELL_IDX   = 0
) (
  input  wire                         clk,
  input  wire                         rst_n,
  // broadcast key and write command
  input  wire [COORD_BITS-1:0]        key_x,
  input  wire [COORD_BITS-1:0]        key_y,
  input  wire [tlc_pkg::ZOOM_W-1:0]   key_z,
  input  tlc_pkg::upd_t               upd,
  input  wire [$clog2(ENTRIES)-1:0]   upd_idx,
  input  wire [tlc_pkg::FRAME_W-1:0]  upd_stamp,
  // token from the previous cell
  input  tlc_pkg::scan_t              up_scan,
  input  wire [$clog2(ENTRIES)-1:0]   up_found_idx,
  input  wire [$clog2(ENTRIES)-1:0]   up_free_idx,
  input  wire [$clog2(ENTRIES)-1:0]   up_best_idx,
  input  wire [tlc_pkg::FRAME_W-1:0]  up_best_stamp,
  input  wire [COORD_BITS-1:0]        up_best_x,
  input  wire [COORD_BITS-1:0]        up_best_y,
  input  wire [tlc_pkg::ZOOM_W-1:0]   up_best_z,
  // token to the next cell, registered
  output tlc_pkg::scan_t              dn_scan,
  output logic [$clog2(ENTRIES)-1:0]  dn_found_idx,
  output logic [$clog2(ENTRIES)-1:0]  dn_free_idx,
  output logic [$clog2(ENTRIES)-1:0]  dn_best_idx,
  output logic [tlc_pkg::FRAME_W-1:0] dn_best_stamp,
  output logic [COORD_BITS-1:0]       dn_best_x,
  output logic [COORD_BITS-1:0]       dn_best_y,
  output logic [tlc_pkg::ZOOM_W-1:0]  dn_best_z
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                        valid_r;
  logic [COORD_BITS-1:0]       x_r;
  logic [COORD_BITS-1:0]       y_r;
  logic [tlc_pkg::ZOOM_W-1:0]  z_r;
  logic [tlc_pkg::FRAME_W-1:0] stamp_r;

  tlc_pkg::scan_t              scan_r, scan_nxt;
  logic [IDX_W-1:0]            found_idx_r, found_idx_nxt;
  logic [IDX_W-1:0]            free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]            best_idx_r, best_idx_nxt;
  logic [tlc_pkg::FRAME_W-1:0] best_stamp_r, best_stamp_nxt;
  logic [COORD_BITS-1:0]       best_x_r, best_x_nxt;
  logic [COORD_BITS-1:0]       best_y_r, best_y_nxt;
  logic [tlc_pkg::ZOOM_W-1:0]  best_z_r, best_z_nxt;

  logic match;
  logic take_best;
  logic wr_me;

  assign match     = valid_r && (x_r == key_x) && (y_r == key_y) && (z_r == key_z);
  assign take_best = valid_r && (!up_scan.have || (stamp_r < up_best_stamp));
  assign wr_me     = upd.we && (upd_idx == MY_IDX);

  // fold this entry into the token
  always_comb begin
    scan_nxt       = up_scan;
    found_idx_nxt  = up_found_idx;
    free_idx_nxt   = up_free_idx;
    best_idx_nxt   = up_best_idx;
    best_stamp_nxt = up_best_stamp;
    best_x_nxt     = up_best_x;
    best_y_nxt     = up_best_y;
    best_z_nxt     = up_best_z;
    if (match && !up_scan.found) begin
      scan_nxt.found = 1'b1;
      found_idx_nxt  = MY_IDX;
    end
    if (!valid_r && !up_scan.free) begin
      scan_nxt.free = 1'b1;
      free_idx_nxt  = MY_IDX;
    end
    if (take_best) begin
      scan_nxt.have  = 1'b1;
      best_idx_nxt   = MY_IDX;
      best_stamp_nxt = stamp_r;
      best_x_nxt     = x_r;
      best_y_nxt     = y_r;
      best_z_nxt     = z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      scan_r  <= '0;
    end else begin
      scan_r <= scan_nxt;
      if (wr_me) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    found_idx_r  <= found_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_x_r     <= best_x_nxt;
    best_y_r     <= best_y_nxt;
    best_z_r     <= best_z_nxt;
    if (wr_me) begin
      stamp_r <= upd_stamp;
      if (upd.set_key) begin
        x_r <= key_x;
        y_r <= key_y;
        z_r <= key_z;
      end
    end
  end

  assign dn_scan       = scan_r;
  assign dn_found_idx  = found_idx_r;
  assign dn_free_idx   = free_idx_r;
  assign dn_best_idx   = best_idx_r;
  assign dn_best_stamp = best_stamp_r;
  assign dn_best_x     = best_x_r;
  assign dn_best_y     = best_y_r;
  assign dn_best_z     = best_z_r;

endmodule

`default_nettype wire

/* rtl/core/tile_cache_lru_by_frame_core.sv */
// Flow: a tick or unknown request goes straight to the commit state; a lookup or install
//   first lets the search token walk the registered cell chain, then commits.
// One beat at a time: a new request is taken only once the last one has committed,
//   and a commit waits while the output register holds an unread result.
// Reset (rst_n low, synchronous): all entries invalid, frame counter and valid count
//   zero, no beat pending; entry keys and stamps are not cleared.
`default_nettype none

module tile_cache_lru_by_frame_core #(
  parameter int ENTRIES    = tlc_pkg::ENTRIES_DEF,
  parameter int COORD_BITS = tlc_pkg::COORD_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  tlc_req_if.sink          in_req,
  tlc_rsp_if.source        out_rsp
);

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int FRAME_W = tlc_pkg::FRAME_W;
  localparam int ZOOM_W  = tlc_pkg::ZOOM_W;
  localparam int TILE_W  = tlc_pkg::TILE_W;
  localparam int SLOT_W  = tlc_pkg::SLOT_W;
  localparam int COUNT_W = tlc_pkg::COUNT_W;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ENTRIES - 1);

  // ---------------------------------------------------------------------------
  // Control and request registers
  // ---------------------------------------------------------------------------
  tlc_pkg::state_t        state_r, state_nxt;
  logic [IDX_W-1:0]       step_r, step_nxt;    // scan cycle counter
  logic [1:0]             req_type_r;
  logic [COORD_BITS-1:0]  key_x_r;
  logic [COORD_BITS-1:0]  key_y_r;
  logic [ZOOM_W-1:0]      key_z_r;
  logic [FRAME_W-1:0]     frame_r, frame_nxt;  // saturating frame counter
  logic [CNT_W-1:0]       vcount_r, vcount_nxt;
  logic                   out_valid_r, out_valid_nxt;
  tlc_pkg::rsp_t          out_data_r, rsp_nxt;

  logic accept;
  logic commit;

  // entry write broadcast
  tlc_pkg::upd_t          upd;
  tlc_pkg::upd_t          upd_cmd;
  logic [IDX_W-1:0]       upd_idx;

  // ---------------------------------------------------------------------------
  // Search token chain: position 0 is the empty token, position ENTRIES the result
  // ---------------------------------------------------------------------------
  tlc_pkg::scan_t         ch_scan       [ENTRIES+1];
  logic [IDX_W-1:0]       ch_found_idx  [ENTRIES+1];
  logic [IDX_W-1:0]       ch_free_idx   [ENTRIES+1];
  logic [IDX_W-1:0]       ch_best_idx   [ENTRIES+1];
  logic [FRAME_W-1:0]     ch_best_stamp [ENTRIES+1];
  logic [COORD_BITS-1:0]  ch_best_x     [ENTRIES+1];
  logic [COORD_BITS-1:0]  ch_best_y     [ENTRIES+1];
  logic [ZOOM_W-1:0]      ch_best_z     [ENTRIES+1];

  assign ch_scan[0]       = '0;
  assign ch_found_idx[0]  = '0;
  assign ch_free_idx[0]   = '0;
  assign ch_best_idx[0]   = '0;
  assign ch_best_stamp[0] = '0;
  assign ch_best_x[0]     = '0;
  assign ch_best_y[0]     = '0;
  assign ch_best_z[0]     = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tlc_cell #(
      .ENTRIES    (ENTRIES),
      .COORD_BITS (COORD_BITS),
      .CELL_IDX   (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .key_x         (key_x_r),
      .key_y         (key_y_r),
      .key_z         (key_z_r),
      .upd           (upd),
      .upd_idx       (upd_idx),
      .upd_stamp     (frame_r),
      .up_scan       (ch_scan[g]),
      .up_found_idx  (ch_found_idx[g]),
      .up_free_idx   (ch_free_idx[g]),
      .up_best_idx   (ch_best_idx[g]),
      .up_best_stamp (ch_best_stamp[g]),
      .up_best_x     (ch_best_x[g]),
      .up_best_y     (ch_best_y[g]),
      .up_best_z     (ch_best_z[g]),
      .dn_scan       (ch_scan[g+1]),
      .dn_found_idx  (ch_found_idx[g+1]),
      .dn_free_idx   (ch_free_idx[g+1]),
      .dn_best_idx   (ch_best_idx[g+1]),
      .dn_best_stamp (ch_best_stamp[g+1]),
      .dn_best_x     (ch_best_x[g+1]),
      .dn_best_y     (ch_best_y[g+1]),
      .dn_best_z     (ch_best_z[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  // Input is taken whenever no beat is in flight; the output register holds the
  // previous result meanwhile.
  assign in_req.ready  = (state_r == tlc_pkg::ST_IDLE);
  assign accept        = in_req.valid && in_req.ready;
  assign commit        = (state_r == tlc_pkg::ST_DONE) && (!out_valid_r || out_rsp.ready);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  // ---------------------------------------------------------------------------
  // FSM, commit decision and result
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    frame_nxt     = frame_r;
    vcount_nxt    = vcount_r;
    out_valid_nxt = out_valid_r;
    upd_cmd       = '0;
    upd_idx       = '0;
    rsp_nxt       = '0;

    // what the finished token asks for
    case (req_type_r)
      tlc_pkg::REQ_TICK: begin
        if (frame_r != '1) begin
          frame_nxt = FRAME_W'(frame_r + 1'b1);
        end
      end
      tlc_pkg::REQ_LOOKUP: begin
        if (ch_scan[ENTRIES].found) begin
          upd_cmd.we  = 1'b1;  // restamp only
          upd_idx     = ch_found_idx[ENTRIES];
          rsp_nxt.hit = 1'b1;
        end
      end
      tlc_pkg::REQ_INSTALL: begin
        upd_cmd.we      = 1'b1;
        upd_cmd.set_key = 1'b1;
        if (ch_scan[ENTRIES].found) begin
          upd_idx     = ch_found_idx[ENTRIES];
          rsp_nxt.hit = 1'b1;
        end else if (ch_scan[ENTRIES].free) begin
          upd_idx    = ch_free_idx[ENTRIES];
          vcount_nxt = CNT_W'(vcount_r + 1'b1);
        end else begin
          // every slot valid: oldest stamp, lowest index on ties
          upd_idx              = ch_best_idx[ENTRIES];
          rsp_nxt.evicted      = 1'b1;
          rsp_nxt.evicted_x    = TILE_W'(ch_best_x[ENTRIES]);
          rsp_nxt.evicted_y    = TILE_W'(ch_best_y[ENTRIES]);
          rsp_nxt.evicted_zoom = ch_best_z[ENTRIES];
        end
      end
      default: begin
        // unused code: behaves as a tick that leaves the counter alone
      end
    endcase
    if (upd_cmd.we) begin
      rsp_nxt.slot = SLOT_W'(upd_idx);
    end
    rsp_nxt.valid_count = COUNT_W'(vcount_nxt);

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      tlc_pkg::ST_IDLE: begin
        if (accept) begin
          step_nxt = '0;
          if ((in_req.data.req_type == tlc_pkg::REQ_LOOKUP) ||
              (in_req.data.req_type == tlc_pkg::REQ_INSTALL)) begin
            state_nxt = tlc_pkg::ST_SCAN;
          end else begin
            state_nxt = tlc_pkg::ST_DONE;
          end
        end
      end
      tlc_pkg::ST_SCAN: begin
        // step the counter until the token reaches the chain end
        step_nxt = IDX_W'(step_r + 1'b1);
        if (step_r == LAST_STEP) begin
          state_nxt = tlc_pkg::ST_DONE;
        end
      end
      tlc_pkg::ST_DONE: begin
        if (commit) begin
          state_nxt     = tlc_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = tlc_pkg::ST_IDLE;
      end
    endcase

    if (!commit) begin
      frame_nxt  = frame_r;
      vcount_nxt = vcount_r;
    end
  end

  assign upd.we      = commit && upd_cmd.we;
  assign upd.set_key = upd_cmd.set_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlc_pkg::ST_IDLE;
      step_r      <= '0;
      frame_r     <= '0;
      vcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      frame_r     <= frame_nxt;
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_req.data.req_type;
      key_x_r    <= COORD_BITS'(in_req.data.tile_x);
      key_y_r    <= COORD_BITS'(in_req.data.tile_y);
      key_z_r    <= in_req.data.tile_zoom;
    end
    if (commit) begin
      out_data_r <= rsp_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= CNT_W'(ENTRIES))
    else $error("valid count above entry count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != tlc_pkg::ST_IDLE))
    else $error("controller idle right after accepting a beat");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.hit |-> !out_data_r.evicted)
    else $error("hit reported together with eviction");

  a_frame_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (frame_r >= $past(frame_r)))
    else $error("frame counter went backwards");

  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> !commit && (state_r == tlc_pkg::ST_IDLE))
    else $error("commit repeated for one beat");

endmodule

`default_nettype wire

/* bench/tile_cache_lru_by_frame_core_test.sv */
// Self-checking bench for the tile tag cache with frame-stamped LRU replacement:
// directed table first, then random traffic from a key pool, checked by a local predictor.
// Depends on tlc_pkg, tlc_req_if, tlc_rsp_if and tile_cache_lru_by_frame_core.
`timescale 1ns / 100ps

module tile_cache_lru_by_frame_core_test;

  localparam int TILE_W    = tlc_pkg::TILE_W;
  localparam int ZOOM_W    = tlc_pkg::ZOOM_W;
  localparam int FRAME_W   = tlc_pkg::FRAME_W;
  localparam int SLOT_W    = tlc_pkg::SLOT_W;
  localparam int COUNT_W   = tlc_pkg::COUNT_W;
  localparam int NUM_SLOTS = tlc_pkg::ENTRIES_DEF;
  localparam int KEY_BITS  = tlc_pkg::COORD_BITS_DEF;
  localparam logic [TILE_W-1:0] KEY_MASK = TILE_W'((64'd1 << KEY_BITS) - 1);
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;  // not decoded, must act as a no-op tick

  localparam int POOL_SIZE   = 96;    // more keys than slots, so the cache churns
  localparam int RAND_BLOCKS = 8;
  localparam int BLOCK_ITEMS = 204;
  localparam int LONG_HOLD   = 400;   // receiver hold-off, cycles
  localparam int SETTLE_CYC  = 2 * NUM_SLOTS + 4;

  typedef struct {
    tlc_pkg::req_t req;
    bit            typed;   // expectation written in the row, not taken from the predictor
    tlc_pkg::rsp_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  tlc_req_if in_req ();
  tlc_rsp_if out_rsp ();

  tile_cache_lru_by_frame_core #(
    .ENTRIES    (NUM_SLOTS),
    .COORD_BITS (KEY_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  // Predictor state: shadow of the tag store and the frame counter.
  logic                slot_valid [NUM_SLOTS];
  logic [TILE_W-1:0]   slot_col   [NUM_SLOTS];
  logic [TILE_W-1:0]   slot_row   [NUM_SLOTS];
  logic [ZOOM_W-1:0]   slot_zoom  [NUM_SLOTS];
  logic [FRAME_W-1:0]  slot_stamp [NUM_SLOTS];
  logic [FRAME_W-1:0]  frame_now;

  tlc_pkg::rsp_t expected_rsps [$];  // results owed by the block, oldest first
  int   error_count;

  int send_idle_pct;
  int stall_pct;
  int hold_requests;        // bumped by the stimulus to ask for one long hold-off

  logic [TILE_W-1:0] pool_x [POOL_SIZE];
  logic [TILE_W-1:0] pool_y [POOL_SIZE];
  logic [ZOOM_W-1:0] pool_z [POOL_SIZE];

  // 50 MHz bench clock, period 20 ns
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #25ms;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Index of the valid slot holding the key, or -1.
  function automatic int find_tile(logic [TILE_W-1:0] kx, logic [TILE_W-1:0] ky,
                                   logic [ZOOM_W-1:0] kz);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_valid[i] && slot_col[i] == kx && slot_row[i] == ky && slot_zoom[i] == kz)
        return i;
    return -1;
  endfunction

  // Applies one request to the shadow state and returns the beat the block owes.
  function automatic tlc_pkg::rsp_t predict_tile_result(tlc_pkg::req_t r);
    tlc_pkg::rsp_t     res;
    logic [TILE_W-1:0] kx;
    logic [TILE_W-1:0] ky;
    int                idx;
    int                nvalid;
    bit                have;
    logic [FRAME_W-1:0] oldest;
    res = '0;
    kx  = r.tile_x & KEY_MASK;
    ky  = r.tile_y & KEY_MASK;
    case (r.req_type)
      tlc_pkg::REQ_TICK: begin
        if (frame_now != '1) frame_now = frame_now + 1'b1;  // saturates
      end
      tlc_pkg::REQ_LOOKUP: begin
        idx = find_tile(kx, ky, r.tile_zoom);
        if (idx >= 0) begin
          slot_stamp[idx] = frame_now;
          res.hit  = 1'b1;
          res.slot = idx[SLOT_W-1:0];
        end
      end
      tlc_pkg::REQ_INSTALL: begin
        idx = find_tile(kx, ky, r.tile_zoom);
        if (idx >= 0) begin
          res.hit = 1'b1;
        end else begin
          // first free slot wins; else smallest stamp, lowest index on ties
          have   = 1'b0;
          oldest = '0;
          idx    = -1;
          for (int i = 0; i < NUM_SLOTS && (idx < 0 || slot_valid[idx]); i++) begin
            if (!slot_valid[i]) begin
              idx = i;
            end else if (!have || slot_stamp[i] < oldest) begin
              oldest = slot_stamp[i];
              idx    = i;
              have   = 1'b1;
            end
          end
          if (slot_valid[idx]) begin
            res.evicted      = 1'b1;
            res.evicted_x    = slot_col[idx];
            res.evicted_y    = slot_row[idx];
            res.evicted_zoom = slot_zoom[idx];
          end
        end
        slot_col[idx]   = kx;
        slot_row[idx]   = ky;
        slot_zoom[idx]  = r.tile_zoom;
        slot_stamp[idx] = frame_now;
        slot_valid[idx] = 1'b1;
        res.slot        = idx[SLOT_W-1:0];
      end
      default: ;  // unknown code: no state change, tick-shaped result
    endcase
    nvalid = 0;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_valid[i]) nvalid++;
    res.valid_count = nvalid[COUNT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    tlc_pkg::rsp_t want;
    tlc_pkg::rsp_t got;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got = out_rsp.data;
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, got);
        error_count++;
      end else begin
        want = expected_rsps.pop_front();
        check_field("hit",          64'(want.hit),          64'(got.hit));
        check_field("slot",         64'(want.slot),         64'(got.slot));
        check_field("evicted",      64'(want.evicted),      64'(got.evicted));
        check_field("evicted_x",    64'(want.evicted_x),    64'(got.evicted_x));
        check_field("evicted_y",    64'(want.evicted_y),    64'(got.evicted_y));
        check_field("evicted_zoom", 64'(want.evicted_zoom), 64'(got.evicted_zoom));
        check_field("valid_count",  64'(want.valid_count),  64'(got.valid_count));
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off on request. The hold is
  // counted here so the sender keeps pushing beats and backs up into the block.
  initial begin
    int seen_holds;
    int hold_left;
    seen_holds    = 0;
    hold_left     = 0;
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != seen_holds) begin
        seen_holds = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tlc_pkg::req_t tile_req(logic [1:0] code, logic [TILE_W-1:0] x,
                                             logic [TILE_W-1:0] y, logic [ZOOM_W-1:0] z);
    tlc_pkg::req_t r;
    r.req_type  = code;
    r.tile_x    = x;
    r.tile_y    = y;
    r.tile_zoom = z;
    return r;
  endfunction

  // Typed expectation for a beat that evicts nothing.
  function automatic tlc_pkg::rsp_t plain_rsp(int hit, int slot, int cnt);
    tlc_pkg::rsp_t res;
    res             = '0;
    res.hit         = hit[0];
    res.slot        = slot[SLOT_W-1:0];
    res.valid_count = cnt[COUNT_W-1:0];
    return res;
  endfunction

  // Mostly in-range zoom levels, sometimes any 5-bit code.
  function automatic logic [ZOOM_W-1:0] random_zoom();
    return ($urandom_range(3) == 0) ? ZOOM_W'($urandom_range(31)) : ZOOM_W'($urandom_range(20));
  endfunction

  // Pool keys give hits, reinstalls and LRU churn; random keys and one-bit
  // neighbors of pool keys probe the key compare.
  function automatic tlc_pkg::req_t random_tile_req();
    tlc_pkg::req_t r;
    int   k;
    int   pick;
    int   sel;
    int   bpos;
    k    = $urandom_range(POOL_SIZE - 1);
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    r = tile_req(tlc_pkg::REQ_INSTALL, pool_x[k], pool_y[k], pool_z[k]);
    if (pick < 10)      r.req_type = tlc_pkg::REQ_TICK;
    else if (pick < 13) r.req_type = REQ_UNKNOWN;
    else if (pick < 50) r.req_type = tlc_pkg::REQ_LOOKUP;
    if (sel < 12 || r.req_type == tlc_pkg::REQ_TICK || r.req_type == REQ_UNKNOWN) begin
      r.tile_x    = TILE_W'($urandom());
      r.tile_y    = TILE_W'($urandom());
      r.tile_zoom = random_zoom();
    end else if (sel < 20) begin
      bpos = $urandom_range(2 * TILE_W + ZOOM_W - 1);
      if (bpos < TILE_W)          r.tile_x[bpos] = ~r.tile_x[bpos];
      else if (bpos < 2 * TILE_W) r.tile_y[bpos - TILE_W] = ~r.tile_y[bpos - TILE_W];
      else                        r.tile_zoom[bpos - 2 * TILE_W] = ~r.tile_zoom[bpos - 2 * TILE_W];
    end
    return r;
  endfunction

  // Called just after a falling edge; returns just after the next falling edge
  // following acceptance, with valid still high so back-to-back beats need no toggle.
  task automatic send_beat(tlc_pkg::req_t r, bit typed, tlc_pkg::rsp_t want);
    tlc_pkg::rsp_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data  <= r;
    do @(posedge clk); while (!in_req.ready);
    pred = predict_tile_result(r);
    expected_rsps.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Park the sender and wait until every owed result beat has come back.
  task automatic drain_results();
    in_req.valid <= 1'b0;
    do @(negedge clk); while (expected_rsps.size() != 0);
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 85; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 85; end
      default: begin send_idle_pct = 16; stall_pct = 16; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t rows [$];
    error_count   = 0;
    hold_requests = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    in_req.valid  = 1'b0;
    in_req.data   = '0;
    rst_n         = 1'b0;
    frame_now     = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_col[i]   = '0;
      slot_row[i]   = '0;
      slot_zoom[i]  = '0;
      slot_stamp[i] = '0;
    end

    // Directed rows. Fixed expectations only where obvious; the rest
    // come from the predictor.
    rows.push_back('{tile_req(tlc_pkg::REQ_LOOKUP, '0, '0, '0), 1'b1,
                     plain_rsp(0, 0, 0)});  // empty cache miss
    rows.push_back('{tile_req(tlc_pkg::REQ_TICK, '0, '0, '0), 1'b1, plain_rsp(0, 0, 0)});
    rows.push_back('{tile_req(REQ_UNKNOWN, '1, '1, '1), 1'b1,
                     plain_rsp(0, 0, 0)});  // ignored code
    rows.push_back('{tile_req(tlc_pkg::REQ_INSTALL, '0, '0, '0), 1'b1,
                     plain_rsp(0, 0, 1)});  // first free slot
    rows.push_back('{tile_req(tlc_pkg::REQ_INSTALL, '1, '1, '1), 1'b1,
                     plain_rsp(0, 1, 2)});  // all-ones key
    rows.push_back('{tile_req(tlc_pkg::REQ_INSTALL, '1, '1, 5'd20), 1'b1,
                     plain_rsp(0, 2, 3)});  // zoom differs only
    rows.push_back('{tile_req(tlc_pkg::REQ_LOOKUP, '1, '1, '1), 1'b1, plain_rsp(1, 1, 3)});
    rows.push_back('{tile_req(tlc_pkg::REQ_INSTALL, '0, '0, '0), 1'b1,
                     plain_rsp(1, 0, 3)});  // reinstall same key
    rows.push_back('{tile_req(tlc_pkg::REQ_LOOKUP, '0, '0, 5'd1), 1'b1, plain_rsp(0, 0, 3)});
    rows.push_back('{tile_req(tlc_pkg::REQ_LOOKUP, '1, '0, '0), 1'b1, plain_rsp(0, 0, 3)});
    rows.push_back('{tile_req(tlc_pkg::REQ_TICK, '1, '1, '1), 1'b1,
                     plain_rsp(0, 0, 3)});  // fields ignored
    rows.push_back('{tile_req(REQ_UNKNOWN, 20'hAAAAA, 20'h55555, 5'd21), 1'b1,
                     plain_rsp(0, 0, 3)});
    rows.push_back('{tile_req(tlc_pkg::REQ_LOOKUP, 20'hAAAAA, 20'h55555, 5'd21), 1'b1,
                     plain_rsp(0, 0, 3)});
    rows.push_back('{tile_req(tlc_pkg::REQ_INSTALL, 20'hAAAAA, 20'h55555, 5'd21), 1'b0, '0});
    rows.push_back('{tile_req(tlc_pkg::REQ_INSTALL, 20'h55555, 20'hAAAAA, 5'd10), 1'b0, '0});
    rows.push_back('{tile_req(tlc_pkg::REQ_TICK, '0, '0, '0), 1'b0, '0});
    rows.push_back('{tile_req(tlc_pkg::REQ_LOOKUP, '0, '0, '0), 1'b0, '0});  // restamp
    rows.push_back('{tile_req(tlc_pkg::REQ_LOOKUP, 20'h55555, 20'hAAAAA, 5'd10), 1'b0, '0});
    rows.push_back('{tile_req(tlc_pkg::REQ_INSTALL, 20'h00001, 20'h80000, 5'd31), 1'b0, '0});

    // key pool: a couple of extremes, the rest random
    pool_x[0] = '1; pool_y[0] = '1; pool_z[0] = 5'd20;
    pool_x[1] = '0; pool_y[1] = '1; pool_z[1] = 5'd0;
    for (int i = 2; i < POOL_SIZE; i++) begin
      pool_x[i] = TILE_W'($urandom());
      pool_y[i] = TILE_W'($urandom());
      pool_z[i] = random_zoom();
    end

    // synchronous reset, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i])
      send_beat(rows[i].req, rows[i].typed, rows[i].want);

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      set_idling(blk);
      if (blk == 2) hold_requests++;       // long sink hold while beats keep coming
      if (blk == 5) drain_results();       // sender pause until the block is empty
      for (int n = 0; n < BLOCK_ITEMS; n++)
        send_beat(random_tile_req(), 1'b0, '0);
    end

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
